/* src/pgs_pkg.sv */
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared types and constants for the process grid split block.
// ----------------------------------------------------------------------------
package pgs_pkg;

    localparam int MAX_PROCS_DEF = 64;
    localparam int PTS_W         = 16;
    localparam int PROCS_W       = 7;
    localparam int SUB_W         = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAND,
        ST_DIVP,
        ST_DIVX,
        ST_DIVY,
        ST_EVAL,
        ST_BEST,
        ST_SETUP,
        ST_DIVSX,
        ST_DIVSY,
        ST_EMIT
    } pgs_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch input word
        logic cand_init; // px <= 1
        logic cand_next; // px <= px + 1
        logic div_start; // start the shared divider
        logic [1:0] div_sel;
        logic eval;      // latch ratio test results
        logic take_best;
        logic setup;     // pick grid
        logic emit_init;
        logic emit_next;
        logic out_load;
    } pgs_cmd_t;

    localparam logic [1:0] DSEL_P  = 2'd0;
    localparam logic [1:0] DSEL_X  = 2'd1;
    localparam logic [1:0] DSEL_Y  = 2'd2;
    localparam logic [1:0] DSEL_SX = 2'd3;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic cand_last;  // px == p
        logic divides;
        logic fits;
        logic better;
        logic emit_last;
    } pgs_stat_t;

endpackage

/* src/pgs_if.sv */
// ----------------------------------------------------------------------------
// pgs_in_if / pgs_out_if
// Valid/ready channels for the process grid split block.
// ----------------------------------------------------------------------------
interface pgs_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] m_points;
    logic [15:0] n_points;
    logic [6:0]  procs;
    modport source (output valid, m_points, n_points, procs, input ready);
    modport sink   (input valid, m_points, n_points, procs, output ready);
endinterface

interface pgs_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  grid_x;
    logic [6:0]  grid_y;
    logic        no_fit;
    logic [5:0]  sub_x;
    logic [5:0]  sub_y;
    logic [15:0] row_first;
    logic [15:0] row_last;
    logic [15:0] col_first;
    logic [15:0] col_last;
    logic        last_result;
    modport source (output valid, grid_x, grid_y, no_fit, sub_x, sub_y, row_first,
                    row_last, col_first, col_last, last_result, input ready);
    modport sink   (input valid, grid_x, grid_y, no_fit, sub_x, sub_y, row_first,
                    row_last, col_first, col_last, last_result, output ready);
endinterface

/* src/pgs_div.sv */
// ----------------------------------------------------------------------------
// pgs_div
// Restoring divider, one quotient bit per cycle, 16-bit dividend.
// ----------------------------------------------------------------------------
module pgs_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [6:0]  divisor,
    output logic        done,
    output logic [15:0] quot,
    output logic [6:0]  rem
);
    logic [15:0] q_reg, q_next;
    logic [6:0]  r_reg, r_next;
    logic [6:0]  d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [7:0]  trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[15]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = 7'(trial - {1'b0, d_reg});
                q_next = {q_reg[14:0], 1'b1};
            end
            else
            begin
                r_next = trial[6:0];
                q_next = {q_reg[14:0], 1'b0};
            end
            cnt_next = 5'(cnt_reg - 5'd1);
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule

/* src/pgs_datapath.sv */
// ----------------------------------------------------------------------------
// pgs_datapath
// Candidate registers, ratio tests, best tracking and bound stepping.
// ----------------------------------------------------------------------------
module pgs_datapath
#(
    parameter int MAX_PROCS = pgs_pkg::MAX_PROCS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pgs_pkg::pgs_cmd_t  cmd,
    output pgs_pkg::pgs_stat_t stat,
    pgs_in_if.sink           in_ch,
    pgs_out_if.source        out_ch,
    input  logic             out_valid
);
    import pgs_pkg::*;

    // procs is 7 bits wide, so any limit past 127 never clips
    localparam logic [6:0] MAXP = (MAX_PROCS > 127) ? 7'd127 : 7'(MAX_PROCS);

    logic [15:0] nx_reg, ny_reg;
    logic [6:0]  p_reg, px_reg, py_reg;
    logic [15:0] fx_reg, ux_reg, fy_reg, uy_reg;
    logic        ok_reg;
    logic [15:0] hn_reg, hd_reg;
    logic        found_reg;
    logic [15:0] bn_reg, bd_reg;
    logic [6:0]  bx_reg, by_reg, gx_reg, gy_reg;
    logic [15:0] bsx_reg, bsy_reg;
    logic [6:0]  rmx_reg, rmy_reg;
    logic [5:0]  cx_reg, cy_reg;
    logic [15:0] rf_reg, cf_reg;
    logic [1:0]  cap_sel_reg;   // what the running divide is for
    logic        cap_sy_reg;

    logic        dv_done;
    logic [15:0] dv_q, dv_a;
    logic [6:0]  dv_r, dv_d;
    logic [15:0] mi, ni;
    logic [6:0]  pi;

    assign mi = (in_ch.m_points >= 16'd1) ? 16'(in_ch.m_points - 16'd1) : '0;
    assign ni = (in_ch.n_points >= 16'd1) ? 16'(in_ch.n_points - 16'd1) : '0;
    always_comb
    begin
        pi = in_ch.procs;
        if (pi == 7'd0)
            pi = 7'd1;
        if (pi > MAXP)
            pi = MAXP;
    end

    // x split divide starts on the same edge that loads gx, so use its source
    always_comb
    begin
        case (cmd.div_sel)
            DSEL_P:  begin dv_a = {9'd0, p_reg}; dv_d = px_reg; end
            DSEL_X:  begin dv_a = nx_reg;        dv_d = px_reg; end
            DSEL_Y:  begin dv_a = ny_reg;        dv_d = py_reg; end
            default: begin dv_a = nx_reg;        dv_d = found_reg ? bx_reg : 7'd1; end
        endcase
    end

    pgs_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(cmd.emit_init ? ny_reg : dv_a),
        .divisor(cmd.emit_init ? gy_reg : dv_d),
        .done(dv_done), .quot(dv_q), .rem(dv_r)
    );

    // ratio test on latched shares
    logic [15:0] n1, d1, n2, d2, hn, hd, ln, ld;
    logic [31:0] c1, c2;
    always_comb
    begin
        n1 = ux_reg;
        d1 = (fy_reg == 16'd0) ? 16'd1 : fy_reg;
        n2 = fx_reg;
        d2 = (uy_reg == 16'd0) ? 16'd1 : uy_reg;
        c1 = n1 * d2;
        c2 = n2 * d1;
        if (c1 >= c2)
        begin
            hn = n1; hd = d1; ln = n2; ld = d2;
        end
        else
        begin
            hn = n2; hd = d2; ln = n1; ld = d1;
        end
    end

    logic [31:0] b1, b2;
    assign b1 = hn_reg * bd_reg;
    assign b2 = bn_reg * hd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nx_reg <= mi;
            ny_reg <= ni;
            p_reg  <= pi;
        end
        if (cmd.cand_init)
            px_reg <= 7'd1;
        else if (cmd.cand_next)
            px_reg <= 7'(px_reg + 7'd1);
        if (cmd.div_start)
        begin
            cap_sel_reg <= cmd.div_sel;
            cap_sy_reg  <= cmd.emit_init;
        end
        if (dv_done)
        begin
            case (cap_sel_reg)
                DSEL_P:
                begin
                    py_reg <= dv_q[6:0];
                end
                DSEL_X:
                begin
                    fx_reg <= dv_q;
                    ux_reg <= 16'(dv_q + {15'd0, dv_r != 7'd0});
                end
                DSEL_Y:
                begin
                    fy_reg <= dv_q;
                    uy_reg <= 16'(dv_q + {15'd0, dv_r != 7'd0});
                end
                default:
                begin
                    if (cap_sy_reg)
                    begin
                        bsy_reg <= dv_q;
                        rmy_reg <= dv_r;
                    end
                    else
                    begin
                        bsx_reg <= dv_q;
                        rmx_reg <= dv_r;
                    end
                end
            endcase
        end
        if (cmd.eval)
        begin
            ok_reg <= ({16'd0, hn} <= {15'd0, hd, 1'b0}) && ({15'd0, ln, 1'b0} >= {16'd0, ld});
            hn_reg <= hn;
            hd_reg <= hd;
        end
        if (cmd.take_best)
        begin
            bn_reg <= hn_reg;
            bd_reg <= hd_reg;
            bx_reg <= px_reg;
            by_reg <= py_reg;
        end
        if (cmd.setup)
        begin
            gx_reg <= found_reg ? bx_reg : 7'd1;
            gy_reg <= found_reg ? by_reg : p_reg;
        end
        if (cmd.emit_init)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            rf_reg <= 16'd1;
            cf_reg <= 16'd1;
        end
        else if (cmd.emit_next)
        begin
            if ({1'b0, cy_reg} == 7'(gy_reg - 7'd1))
            begin
                cy_reg <= '0;
                cf_reg <= 16'd1;
                cx_reg <= 6'(cx_reg + 6'd1);
                rf_reg <= 16'(rf_reg + bsx_reg + {15'd0, {1'b0, cx_reg} < rmx_reg});
            end
            else
            begin
                cy_reg <= 6'(cy_reg + 6'd1);
                cf_reg <= 16'(cf_reg + bsy_reg + {15'd0, {1'b0, cy_reg} < rmy_reg});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (cmd.load)
            found_reg <= 1'b0;
        else if (cmd.take_best)
            found_reg <= 1'b1;
    end

    logic [15:0] rl, cl;
    logic        lst;
    assign rl  = 16'(rf_reg + bsx_reg + {15'd0, {1'b0, cx_reg} < rmx_reg} - 16'd1);
    assign cl  = 16'(cf_reg + bsy_reg + {15'd0, {1'b0, cy_reg} < rmy_reg} - 16'd1);
    assign lst = ({1'b0, cx_reg} == 7'(gx_reg - 7'd1))
              && ({1'b0, cy_reg} == 7'(gy_reg - 7'd1));

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_ch.grid_x      <= gx_reg;
            out_ch.grid_y      <= gy_reg;
            out_ch.no_fit      <= ~found_reg;
            out_ch.sub_x       <= cx_reg;
            out_ch.sub_y       <= cy_reg;
            out_ch.row_first   <= rf_reg;
            out_ch.row_last    <= rl;
            out_ch.col_first   <= cf_reg;
            out_ch.col_last    <= cl;
            out_ch.last_result <= lst;
        end
    end

    assign out_ch.valid   = out_valid;
    assign stat.div_done  = dv_done;
    assign stat.cand_last = (px_reg == p_reg);
    // remainder is final while done is high
    assign stat.divides   = (dv_r == 7'd0);
    assign stat.fits      = ok_reg;
    assign stat.better    = ~found_reg || (b1 < b2);
    assign stat.emit_last = lst;
endmodule

/* src/pgs_ctrl.sv */
// ----------------------------------------------------------------------------
// pgs_ctrl
// Sequencer: divisor search, grid set-up, then one word per subdomain.
// ----------------------------------------------------------------------------
module pgs_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    input  pgs_pkg::pgs_stat_t stat,
    output pgs_pkg::pgs_cmd_t  cmd
);
    import pgs_pkg::*;

    pgs_state_t st_reg, st_next;
    logic       ov_reg, ov_next;
    logic       last_reg, last_next;

    // output register free: empty, or being taken now
    logic ofree;
    assign ofree = ~ov_reg | out_ready;

    // CAND is a gap state so the divider sees the updated px and inputs
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:  if (in_valid) st_next = ST_CAND;
            ST_CAND:  st_next = ST_DIVP;
            ST_DIVP:  if (stat.div_done) st_next = stat.divides ? ST_DIVX : ST_BEST;
            ST_DIVX:  if (stat.div_done) st_next = ST_DIVY;
            ST_DIVY:  if (stat.div_done) st_next = ST_EVAL;
            ST_EVAL:  st_next = ST_BEST;
            ST_BEST:  st_next = stat.cand_last ? ST_SETUP : ST_CAND;
            ST_SETUP: st_next = ST_DIVSX;
            ST_DIVSX: if (stat.div_done) st_next = ST_DIVSY;
            ST_DIVSY: if (stat.div_done) st_next = ST_EMIT;
            ST_EMIT:  if (ofree && last_reg) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    // evaluate flag: DIVP passes through BEST without a fit check
    logic tested_reg, tested_next;

    always_comb
    begin
        cmd       = '0;
        cmd.div_sel = DSEL_P;
        in_ready  = 1'b0;
        ov_next   = ov_reg & ~out_ready;
        last_next = last_reg;
        tested_next = tested_reg;
        case (st_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load      = in_valid;
                cmd.cand_init = in_valid;
                last_next     = 1'b0;
            end
            ST_DIVP:
            begin
                cmd.div_sel = DSEL_P;
                tested_next = 1'b0;
            end
            ST_DIVX: cmd.div_sel = DSEL_X;
            ST_DIVY: cmd.div_sel = DSEL_Y;
            ST_EVAL:
            begin
                cmd.eval    = 1'b1;
                tested_next = 1'b1;
            end
            ST_BEST:
            begin
                cmd.take_best = tested_reg & stat.fits & stat.better;
                cmd.cand_next = ~stat.cand_last;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_DIVSX: cmd.div_sel = DSEL_SX;
            ST_DIVSY:
            begin
                cmd.div_sel   = DSEL_SX;
                cmd.emit_init = 1'b1;
            end
            ST_EMIT:
            begin
                if (ofree && !last_reg)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.emit_next = ~stat.emit_last;
                    ov_next       = 1'b1;
                    last_next     = stat.emit_last;
                end
            end
            default: ;
        endcase
        // divider kick on entry into each divide state
        if (st_next != st_reg &&
            (st_next == ST_DIVP || st_next == ST_DIVX || st_next == ST_DIVY ||
             st_next == ST_DIVSX || st_next == ST_DIVSY))
        begin
            cmd.div_start = 1'b1;
            case (st_next)
                ST_DIVP:  cmd.div_sel = DSEL_P;
                ST_DIVX:  cmd.div_sel = DSEL_X;
                ST_DIVY:  cmd.div_sel = DSEL_Y;
                default:  cmd.div_sel = DSEL_SX;
            endcase
            cmd.emit_init = (st_next == ST_DIVSY);
        end
        if (st_reg == ST_DIVSY && !stat.div_done)
            cmd.emit_init = 1'b1;
        if (st_reg == ST_DIVSY && stat.div_done)
            cmd.emit_init = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            ov_reg     <= 1'b0;
            last_reg   <= 1'b0;
            tested_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            ov_reg     <= ov_next;
            last_reg   <= last_next;
            tested_reg <= tested_next;
        end
    end

    assign out_valid = ov_reg;

`ifndef NO_ASSERTIONS
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> st_reg == ST_IDLE)
        else $error("input taken while busy");
    a_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st_reg == ST_EMIT)
        else $error("output load outside emit");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg)
        else $error("result dropped");
`endif
endmodule

/* src/process_grid_split.sv */
// ----------------------------------------------------------------------------
// process_grid_split
// Chooses a process grid for P processes and emits the even split bounds.
// ----------------------------------------------------------------------------
// One input word (m_points, n_points, procs) produces grid_x*grid_y result
// words, sub_x outer and sub_y inner, last_result marking the final one.
// The block works on one word at a time: the divisor search runs every
// candidate px = 1..P through a shared restoring divider (P/px, then nx/px
// and ny/py for true divisors). Two more divides set up the split, then one
// result word per cycle while the sink keeps taking them. in.ready is high
// only between input words; the output register holds a result until taken.
module process_grid_split
#(
    parameter int MAX_PROCS = pgs_pkg::MAX_PROCS_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    pgs_in_if.sink    in_ch,
    pgs_out_if.source out_ch
);
    import pgs_pkg::*;

    pgs_cmd_t  cmd;
    pgs_stat_t stat;
    logic      ov;

    pgs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_ready(out_ch.ready), .out_valid(ov),
        .stat(stat), .cmd(cmd)
    );

    pgs_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_ch(in_ch), .out_ch(out_ch), .out_valid(ov)
    );
endmodule

/* verif/pgs_grid_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pgs_grid_checker
// Watches both channels of the process grid split block. For every accepted
// input word it predicts the grid choice and the subdomain bounds, and checks
// each accepted result word against the oldest prediction.
// ----------------------------------------------------------------------------
module pgs_grid_checker
#(
    parameter int MAX_PROCS = pgs_pkg::MAX_PROCS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    pgs_in_if.sink  mon_in,
    pgs_out_if.sink mon_out,
    output int      fail_count,
    output int      pending
);

    typedef struct packed {
        logic [6:0]  grid_x;
        logic [6:0]  grid_y;
        logic        no_fit;
        logic [5:0]  sub_x;
        logic [5:0]  sub_y;
        logic [15:0] row_first;
        logic [15:0] row_last;
        logic [15:0] col_first;
        logic [15:0] col_last;
        logic        last_result;
    } subdomain_t;

    subdomain_t bounds_q[$];

    assign pending = bounds_q.size();

    // Even split: piece c of g over n points, laid out from index 1.
    function automatic void piece(input int unsigned n, input int unsigned g,
                                  input int unsigned c,
                                  output logic [15:0] first, output logic [15:0] last);
        int unsigned base;
        int unsigned rem;
        int unsigned len;
        int unsigned start;
        base  = n / g;
        rem   = n % g;
        len   = base + ((c < rem) ? 1 : 0);
        start = 1 + c * base + ((c < rem) ? c : rem);
        first = start[15:0];
        last  = 16'(start + len - 1);
    endfunction

    task automatic split_grid(input logic [15:0] m, input logic [15:0] n,
                              input logic [6:0] procs);
        int unsigned nx;
        int unsigned ny;
        int unsigned p;
        int unsigned py;
        int unsigned fx;
        int unsigned ux;
        int unsigned fy;
        int unsigned uy;
        int unsigned gx;
        int unsigned gy;
        longint unsigned n1, d1, n2, d2, hn, hd, ln, ld, bn, bd;
        bit found;
        subdomain_t s;
        nx = (m >= 1) ? m - 1 : 0;
        ny = (n >= 1) ? n - 1 : 0;
        p  = (procs == 0) ? 1 : procs;
        if (p > MAX_PROCS)
            p = MAX_PROCS;
        found = 0;
        bn = 0;
        bd = 1;
        gx = 1;
        gy = p;
        for (int unsigned px = 1; px <= p; px++)
        begin
            if (p % px != 0)
                continue;
            py = p / px;
            fx = nx / px;
            ux = (nx + px - 1) / px;
            fy = ny / py;
            uy = (ny + py - 1) / py;
            n1 = ux;
            d1 = (fy != 0) ? fy : 1;
            n2 = fx;
            d2 = (uy != 0) ? uy : 1;
            if (n1 * d2 >= n2 * d1)
            begin
                hn = n1; hd = d1; ln = n2; ld = d2;
            end
            else
            begin
                hn = n2; hd = d2; ln = n1; ld = d1;
            end
            if (hn > 2 * hd || 2 * ln < ld)
                continue;
            if (!found || hn * bd < bn * hd)
            begin
                found = 1;
                bn = hn;
                bd = hd;
                gx = px;
                gy = py;
            end
        end
        for (int unsigned cx = 0; cx < gx; cx++)
        begin
            for (int unsigned cy = 0; cy < gy; cy++)
            begin
                s.grid_x      = gx[6:0];
                s.grid_y      = gy[6:0];
                s.no_fit      = !found;
                s.sub_x       = cx[5:0];
                s.sub_y       = cy[5:0];
                piece(nx, gx, cx, s.row_first, s.row_last);
                piece(ny, gy, cy, s.col_first, s.col_last);
                s.last_result = (cx + 1 == gx) && (cy + 1 == gy);
                bounds_q.push_back(s);
            end
        end
    endtask

    always @(posedge clk)
    begin
        subdomain_t got;
        subdomain_t exp_s;
        if (rst_n)
        begin
            if (mon_in.valid && mon_in.ready)
                split_grid(mon_in.m_points, mon_in.n_points, mon_in.procs);
            if (mon_out.valid && mon_out.ready)
            begin
                got = '{mon_out.grid_x, mon_out.grid_y, mon_out.no_fit, mon_out.sub_x,
                        mon_out.sub_y, mon_out.row_first, mon_out.row_last,
                        mon_out.col_first, mon_out.col_last, mon_out.last_result};
                if (bounds_q.size() == 0)
                begin
                    $error("unexpected result word");
                    fail_count++;
                end
                else
                begin
                    exp_s = bounds_q.pop_front();
                    if (got.grid_x != exp_s.grid_x)
                    begin
                        $error("grid_x exp %0d got %0d", exp_s.grid_x, got.grid_x);
                        fail_count++;
                    end
                    if (got.grid_y != exp_s.grid_y)
                    begin
                        $error("grid_y exp %0d got %0d", exp_s.grid_y, got.grid_y);
                        fail_count++;
                    end
                    if (got.no_fit != exp_s.no_fit)
                    begin
                        $error("no_fit exp %0d got %0d", exp_s.no_fit, got.no_fit);
                        fail_count++;
                    end
                    if (got.sub_x != exp_s.sub_x)
                    begin
                        $error("sub_x exp %0d got %0d", exp_s.sub_x, got.sub_x);
                        fail_count++;
                    end
                    if (got.sub_y != exp_s.sub_y)
                    begin
                        $error("sub_y exp %0d got %0d", exp_s.sub_y, got.sub_y);
                        fail_count++;
                    end
                    if (got.row_first != exp_s.row_first)
                    begin
                        $error("row_first exp %0d got %0d", exp_s.row_first, got.row_first);
                        fail_count++;
                    end
                    if (got.row_last != exp_s.row_last)
                    begin
                        $error("row_last exp %0d got %0d", exp_s.row_last, got.row_last);
                        fail_count++;
                    end
                    if (got.col_first != exp_s.col_first)
                    begin
                        $error("col_first exp %0d got %0d", exp_s.col_first, got.col_first);
                        fail_count++;
                    end
                    if (got.col_last != exp_s.col_last)
                    begin
                        $error("col_last exp %0d got %0d", exp_s.col_last, got.col_last);
                        fail_count++;
                    end
                    if (got.last_result != exp_s.last_result)
                    begin
                        $error("last_result exp %0d got %0d",
                               exp_s.last_result, got.last_result);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

/* verif/process_grid_split_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// process_grid_split_tb
// Drives grid requests into the process grid split block with random gaps
// and sink stalls; a checker beside the block predicts every subdomain word.
// ----------------------------------------------------------------------------
module process_grid_split_tb;

    localparam int N_RANDOM    = 122;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 3000;   // one full divisor search

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    bit   hold_sink;   // long sink hold-off to back up the block

    pgs_in_if  in_ch();
    pgs_out_if out_ch();

    process_grid_split u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    pgs_grid_checker u_chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mon_in     (in_ch.sink),
        .mon_out    (out_ch.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Send one request word: random idle gap first, then hold until taken.
    // ready follows only the controller state, so the value seen at the
    // falling edge holds through the next rising edge.
    task automatic send_word(input logic [15:0] m, input logic [15:0] n,
                             input logic [6:0] p);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.m_points <= m;
        in_ch.n_points <= n;
        in_ch.procs    <= p;
        do
            @(negedge clk);
        while (!in_ch.ready);
        @(posedge clk);
    endtask

    // Points: mostly small, sometimes extreme, full range now and then.
    function automatic logic [15:0] rand_points();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 3));
            1: return 16'($urandom_range(65530, 65535));
            2: return 16'($urandom);
            default: return 16'($urandom_range(2, 200));
        endcase
    endfunction

    // Procs: mostly small so result runs stay short; the whole 7-bit field
    // shows up too, including zero and values above the saturation point.
    function automatic logic [6:0] rand_procs();
        case ($urandom_range(0, 5))
            0: return 7'($urandom);
            1: return 7'($urandom_range(60, 64));
            default: return 7'($urandom_range(1, 12));
        endcase
    endfunction

    // Sink side: random stall per word, plus one long hold-off stretch.
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, 19);
            if ($urandom_range(0, 2) == 0)
                stall = 0;
            while (hold_sink || stall > 0)
            begin
                out_ch.ready <= 1'b0;
                if (stall > 0)
                    stall--;
                @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    // Hold-off timer, counted in its own process.
    initial
    begin
        hold_sink = 1'b0;
        wait (cycle_count == 3000);
        hold_sink = 1'b1;
        repeat (20000)
            @(posedge clk);
        hold_sink = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.m_points = '0;
        in_ch.n_points = '0;
        in_ch.procs    = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero/too-few points, zero and oversized procs,
        // empty pieces, lopsided grids that find no fit, single process
        send_word(16'd2, 16'd2, 7'd1);
        send_word(16'd65535, 16'd65535, 7'd64);
        send_word(16'd0, 16'd1, 7'd4);
        send_word(16'd1, 16'd100, 7'd6);
        send_word(16'd50, 16'd50, 7'd0);
        send_word(16'd100, 16'd100, 7'd127);
        send_word(16'd100, 16'd100, 7'd65);
        send_word(16'd3, 16'd3, 7'd16);
        send_word(16'd65535, 16'd2, 7'd8);
        send_word(16'd2, 16'd65535, 7'd8);
        send_word(16'd1000, 16'd10, 7'd7);
        send_word(16'd101, 16'd101, 7'd4);
        send_word(16'd101, 16'd51, 7'd8);
        send_word(16'd10, 16'd10, 7'd37);
        send_word(16'd65535, 16'd32768, 7'd12);
        send_word(16'hAAAA, 16'h5555, 7'h55);
        send_word(16'h5555, 16'hAAAA, 7'h2A);
        send_word(16'd17, 16'd33, 7'd9);

        for (int i = 0; i < N_RANDOM; i++)
            send_word(rand_points(), rand_points(), rand_procs());
        in_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
src/pgs_pkg.sv
src/pgs_if.sv
src/pgs_div.sv
src/pgs_datapath.sv
src/pgs_ctrl.sv
src/process_grid_split.sv
verif/pgs_grid_checker.sv
verif/process_grid_split_tb.sv
